### src/open_addressing_hash_probe_top_assert.svh
// Assertion macros for the open-addressing hash probe checker
`ifndef OPEN_ADDRESSING_HASH_PROBE_TOP_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_PROBE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define OHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash probe check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define OHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash probe check failed");

`endif

### src/ohp_pkg.sv
// Shared constants for the open-addressing hash probe
`timescale 1ns / 1ps

package ohp_pkg;

  // Storage geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = KEY_WIDTH + 1;

  // Fixed field widths
  localparam int SIZE_W   = 11;
  localparam int POS_W    = 10;
  localparam int KEYF_W   = 32;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Register indexes
  localparam logic REG_PROBE_MODE = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  // Request kinds
  localparam logic ACT_FIND   = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Probe modes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_QUAD   = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

endpackage

### src/ohp_divider.sv
// Bit-serial remainder unit: key modulo table size, one key bit per cycle
`timescale 1ns / 1ps

module ohp_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ohp_pkg::KEY_WIDTH-1:0] dividend_i,
  input  logic [ohp_pkg::SIZE_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [ohp_pkg::SIZE_W-1:0]    rem_o
);
  import ohp_pkg::*;

  localparam int CNT_W = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0] shift_q, shift_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      trial_sub;

  // Shift in the next dividend bit and subtract the divisor where it fits
  assign trial     = {rem_q, shift_q[KEY_WIDTH-1]};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_W'(KEY_WIDTH - 1);
      shift_d = dividend_i;
      rem_d   = '0;
    end else if (busy_q) begin
      shift_d = {shift_q[KEY_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial_sub[SIZE_W-1:0];
      end else begin
        rem_d = trial[SIZE_W-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the working words
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### src/open_addressing_hash_probe_top.sv
// Open-addressing hash table: find by probing, insert by slot
//
// Keys live in one 1024-entry synchronous memory, each entry an occupancy bit
// and a 32-bit key. After reset the block sweeps the memory to mark every slot
// empty and takes no request meanwhile; register writes are taken at any time.
// An insert writes its slot in S_INSERT and then loads the result register
// from S_DONE. A find first forms key modulo table size in a bit-serial
// remainder unit, then reads one slot per cycle from the memory port, probing
// at most table_size slots. The memory read port sets the probe rate. A
// finished result waits in the output register while the next request is
// already accepted. A find that probes table_size slots without a match or an
// empty slot returns position 0 with table_full set.
`timescale 1ns / 1ps

module open_addressing_hash_probe_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ohp_pkg::IN_DW-1:0]     s_axis_tdata,  // [31:0] key, [41:32] slot_index
  input  logic                          s_axis_tuser,  // [0] action
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ohp_pkg::OUT_DW-1:0]    m_axis_tdata,  // [9:0] position
  output logic [1:0]                    m_axis_tuser,  // [0] hit, [1] table_full
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ohp_pkg::CFG_AW-1:0]    paddr,
  input  logic [ohp_pkg::CFG_DW-1:0]    pwdata,
  output logic [ohp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import ohp_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Registers
  logic              mode_q;
  logic [SIZE_W-1:0] size_q;
  logic              cfg_wr;
  logic              cfg_sel;
  logic [SIZE_W-1:0] size_eff;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_QUAD;
      size_q <= SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PROBE_MODE: mode_q <= pwdata[0];
        REG_TABLE_SIZE: size_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_PROBE_MODE: prdata = CFG_DW'(mode_q);
      REG_TABLE_SIZE: prdata = CFG_DW'(size_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp the modulus to 1..TABLE_DEPTH
  always_comb begin
    if (size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(TABLE_DEPTH)) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = size_q;
    end
  end

  // Control and request registers
  logic [2:0]          state_q, state_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic                act_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [POS_W-1:0]    slot_q;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]   inc_q, inc_d;
  logic [SIZE_W-1:0]   n_q, n_d;
  logic [POS_W-1:0]    res_pos_q, res_pos_d;
  logic                res_hit_q, res_hit_d;
  logic                res_full_q, res_full_d;
  logic                in_acc;

  // Memory ports
  logic [ENTRY_W-1:0]  slot_mem_q [TABLE_DEPTH];
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [SLOT_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata_q;

  // Remainder unit
  logic                div_start;
  logic                div_done;
  logic [SIZE_W-1:0]   div_rem;

  ohp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (KEY_WIDTH'(s_axis_tdata[KEYF_W-1:0])),
    .divisor_i  (size_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Output register
  logic              m_valid_q;
  logic [POS_W-1:0]  m_pos_q;
  logic              m_hit_q;
  logic              m_full_q;
  logic              out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign div_start     = in_acc && (s_axis_tuser == ACT_FIND);
  assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  // Next probe position and next step, both kept below the modulus
  logic [SIZE_W-1:0] pos_sum;
  logic [SLOT_W-1:0] pos_next;
  logic [SIZE_W-1:0] inc_sum;
  logic [SIZE_W-1:0] inc_red;
  logic [SLOT_W-1:0] inc_next;
  logic [SIZE_W-1:0] step_add;

  assign step_add = (mode_q == MODE_QUAD) ? SIZE_W'(2) : SIZE_W'(1);

  always_comb begin
    pos_sum = SIZE_W'(pos_q) + SIZE_W'(inc_q);
    if (pos_sum >= size_eff) begin
      pos_sum = pos_sum - size_eff;
    end
    pos_next = pos_sum[SLOT_W-1:0];
    inc_sum  = SIZE_W'(inc_q) + step_add;
    inc_red  = (inc_sum >= size_eff) ? (inc_sum - size_eff) : inc_sum;
    if (inc_red >= size_eff) begin
      inc_red = inc_red - size_eff;
    end
    inc_next = inc_red[SLOT_W-1:0];
  end

  // Entry fields as read back
  logic                 rd_occ;
  logic [KEY_WIDTH-1:0] rd_key;

  assign rd_occ = mem_rdata_q[ENTRY_W-1];
  assign rd_key = mem_rdata_q[KEY_WIDTH-1:0];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    inc_d      = inc_q;
    n_d        = n_q;
    res_pos_d  = res_pos_q;
    res_hit_d  = res_hit_q;
    res_full_d = res_full_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    mem_raddr  = pos_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser == ACT_INSERT) ? S_INSERT : S_DIV;
        end
      end
      S_INSERT: begin
        mem_we     = 1'b1;
        mem_waddr  = SLOT_W'(slot_q);
        mem_wdata  = {1'b1, key_q};
        res_pos_d  = slot_q;
        res_hit_d  = 1'b0;
        res_full_d = 1'b0;
        state_d    = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          pos_d   = SLOT_W'(div_rem);
          inc_d   = (size_eff == SIZE_W'(1)) ? '0 : SLOT_W'(1);
          n_d     = SIZE_W'(1);
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        mem_raddr = pos_q;
        state_d   = S_PROBE;
      end
      S_PROBE: begin
        if (!rd_occ) begin
          res_pos_d  = POS_W'(pos_q);
          res_hit_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = S_DONE;
        end else if (rd_key == key_q) begin
          res_pos_d  = POS_W'(pos_q);
          res_hit_d  = 1'b1;
          res_full_d = 1'b0;
          state_d    = S_DONE;
        end else if (n_q == size_eff) begin
          res_pos_d  = '0;
          res_hit_d  = 1'b0;
          res_full_d = 1'b1;
          state_d    = S_DONE;
        end else begin
          pos_d     = pos_next;
          inc_d     = inc_next;
          n_d       = n_q + SIZE_W'(1);
          mem_raddr = pos_next;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Capture the request and the probe walk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tuser;
      key_q  <= KEY_WIDTH'(s_axis_tdata[KEYF_W-1:0]);
      slot_q <= s_axis_tdata[KEYF_W+POS_W-1:KEYF_W];
    end
    pos_q      <= pos_d;
    inc_q      <= inc_d;
    n_q        <= n_d;
    res_pos_q  <= res_pos_d;
    res_hit_q  <= res_hit_d;
    res_full_q <= res_full_d;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= slot_mem_q[mem_raddr];
  end

  // Result register; an insert never reports hit or full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_pos_q  <= res_pos_q;
      m_hit_q  <= res_hit_q && (act_q == ACT_FIND);
      m_full_q <= res_full_q && (act_q == ACT_FIND);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'(m_pos_q);
  assign m_axis_tuser  = {m_full_q, m_hit_q};

endmodule

### src/ohp_checker.sv
// Port-level checker for the hash probe top level, with its bind
`timescale 1ns / 1ps

`include "open_addressing_hash_probe_top_assert.svh"

module ohp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ohp_pkg::OUT_DW-1:0] m_axis_tdata,
  input logic [1:0]                 m_axis_tuser
);
  import ohp_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track requests whose result is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  `OHP_ASSERT_NOW(a_no_extra_result, out_acc, pend_q != 2'd0)
  `OHP_ASSERT_NOW(a_two_in_flight, in_acc, pend_q <= 2'd1)
  `OHP_ASSERT_NOW(a_full_excludes_hit, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0] && (m_axis_tdata == '0))
  `OHP_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind open_addressing_hash_probe_top ohp_checker u_ohp_checker (.*);

### dv/tb.sv
// Self-checking testbench for the open-addressing hash probe block
`timescale 1ns / 1ps

module tb;
  import ohp_pkg::*;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic              act;
    logic [KEYF_W-1:0] key;
    logic [POS_W-1:0]  slot;
  } probe_req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             hit;
    logic             table_full;
  } probe_res_t;

  typedef struct {
    row_kind_e         kind;
    probe_req_t        req;
    logic              reg_idx;
    logic [CFG_DW-1:0] value;
    bit                typed;
    probe_res_t        res;
  } dir_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata  = '0;  // [31:0] key, [41:32] slot_index
  logic              s_axis_tuser  = 1'b0; // [0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;         // [9:0] position
  logic [1:0]        m_axis_tuser;         // [0] hit, [1] table_full
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [CFG_AW-1:0] paddr         = '0;
  logic [CFG_DW-1:0] pwdata        = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Shadow copy of the table and its registers
  logic              occupied [TABLE_DEPTH];
  logic [KEYF_W-1:0] stored   [TABLE_DEPTH];
  logic              mode_q = MODE_QUAD;
  logic [SIZE_W-1:0] size_q = SIZE_RESET;

  probe_res_t        results_due[$];
  dir_row_t          dir_rows[$];
  logic [KEYF_W-1:0] placed_keys[$];

  int errors     = 0;
  int n_find     = 0;
  int n_insert   = 0;
  int n_hit      = 0;
  int n_full     = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int stall_left = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  int phase_size[12] = '{1024, 1, 13, 2, 64, 1024, 31, 5, 128, 8, 0, 997};

  open_addressing_hash_probe_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the shadow table and return the slot it lands on
  function automatic probe_res_t table_step(input probe_req_t req);
    probe_res_t res;
    int         eff;
    int         pos;
    int         step;
    res = '0;
    if (req.act == ACT_INSERT) begin
      stored[req.slot]   = req.key;
      occupied[req.slot] = 1'b1;
      res.position       = req.slot;
      return res;
    end
    eff = (size_q == 0) ? 1 : (size_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_q);
    pos = int'(req.key % 32'(eff));
    for (int n = 1; n <= eff; n++) begin
      if (!occupied[pos]) begin
        res.position = POS_W'(pos);
        return res;
      end
      if (stored[pos] == req.key) begin
        res.position = POS_W'(pos);
        res.hit      = 1'b1;
        return res;
      end
      step = (mode_q == MODE_QUAD) ? 2 * n - 1 : n;
      pos  = (pos + step) % eff;
    end
    res.table_full = 1'b1;
    return res;
  endfunction

  // Mix of random, colliding and small keys
  function automatic logic [KEYF_W-1:0] fresh_key(input int span);
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return KEYF_W'($urandom_range(0, 7) + span * $urandom_range(0, 100000));
      default: return KEYF_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic add_req(input logic act, input logic [KEYF_W-1:0] key,
                         input logic [POS_W-1:0] slot, input bit typed,
                         input logic [POS_W-1:0] position, input logic hit,
                         input logic table_full);
    dir_row_t row;
    row.kind    = ROW_REQ;
    row.req     = '{act: act, key: key, slot: slot};
    row.reg_idx = REG_PROBE_MODE;
    row.value   = '0;
    row.typed   = typed;
    row.res     = '{position: position, hit: hit, table_full: table_full};
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic reg_idx, input logic [CFG_DW-1:0] value);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.req     = '0;
    row.reg_idx = reg_idx;
    row.value   = value;
    row.typed   = 1'b0;
    row.res     = '0;
    dir_rows.push_back(row);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input logic reg_idx, input logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == REG_PROBE_MODE) begin
      mode_q = value[0];
    end else begin
      size_q = value[SIZE_W-1:0];
      n_settings++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop the request valid and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Hold one request until accepted, then record what it should return
  task automatic send_request(input probe_req_t req, input bit typed,
                              input probe_res_t typed_res, output probe_res_t pred);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.act;
    s_axis_tdata  <= {{(IN_DW-KEYF_W-POS_W){1'b0}}, req.slot, req.key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = table_step(req);
    if (req.act == ACT_INSERT) n_insert++;
    else n_find++;
    results_due.push_back(typed ? typed_res : pred);
  endtask

  // Result sink: stall in random bursts while enabled
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest outstanding one
  always @(posedge clk_i) begin : check_results
    probe_res_t got;
    probe_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.position   = m_axis_tdata[POS_W-1:0];
      got.hit        = m_axis_tuser[0];
      got.table_full = m_axis_tuser[1];
      n_checked++;
      if (got.hit) n_hit++;
      if (got.table_full) n_full++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual position %0d hit %0b full %0b",
                 $time, got.position, got.hit, got.table_full);
      end else begin
        want = results_due.pop_front();
        if (got.position !== want.position) begin
          errors++;
          $display("%0t: position mismatch, expected %0d, actual %0d",
                   $time, want.position, got.position);
        end
        if (got.hit !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, got.hit);
        end
        if (got.table_full !== want.table_full) begin
          errors++;
          $display("%0t: table_full mismatch, expected %0b, actual %0b",
                   $time, want.table_full, got.table_full);
        end
      end
    end
  end

  initial begin : stimulus
    probe_req_t req;
    probe_res_t pred;
    int         count;
    int         pick;
    int         span;

    foreach (occupied[i]) occupied[i] = 1'b0;

    // Directed rows: reset state, extremes, clamped sizes, full tables
    add_req(ACT_FIND,   32'h0000_0000, 10'd0,     1'b1, 10'd0,    1'b0, 1'b0);
    add_req(ACT_FIND,   32'hFFFF_FFFF, 10'h3FF,   1'b1, 10'd1023, 1'b0, 1'b0);
    add_req(ACT_INSERT, 32'hFFFF_FFFF, 10'd1023,  1'b1, 10'd1023, 1'b0, 1'b0);
    add_req(ACT_FIND,   32'hFFFF_FFFF, 10'd0,     1'b1, 10'd1023, 1'b1, 1'b0);
    add_req(ACT_INSERT, 32'h0000_03FF, 10'd0,     1'b1, 10'd0,    1'b0, 1'b0);
    add_req(ACT_FIND,   32'h0000_03FF, 10'd0,     1'b0, '0, 1'b0, 1'b0);
    add_req(ACT_FIND,   32'h0000_07FF, 10'h155,   1'b0, '0, 1'b0, 1'b0);
    add_req(ACT_INSERT, 32'h0000_0000, 10'd512,   1'b1, 10'd512,  1'b0, 1'b0);
    // Size zero acts as a single slot
    add_cfg(REG_PROBE_MODE, CFG_DW'(MODE_LINEAR));
    add_cfg(REG_TABLE_SIZE, 32'd0);
    add_req(ACT_FIND,   32'd12345,     10'd0,     1'b1, 10'd0,    1'b0, 1'b1);
    add_req(ACT_FIND,   32'h0000_03FF, 10'd0,     1'b1, 10'd0,    1'b1, 1'b0);
    add_cfg(REG_TABLE_SIZE, 32'd1);
    add_req(ACT_INSERT, 32'hA5A5_A5A5, 10'd0,     1'b1, 10'd0,    1'b0, 1'b0);
    add_req(ACT_FIND,   32'hA5A5_A5A5, 10'd0,     1'b1, 10'd0,    1'b1, 1'b0);
    // Fill a four-slot table, then miss on it
    add_cfg(REG_TABLE_SIZE, 32'd4);
    add_req(ACT_INSERT, 32'h5A5A_5A5A, 10'd1,     1'b1, 10'd1,    1'b0, 1'b0);
    add_req(ACT_INSERT, 32'h0000_0006, 10'd2,     1'b1, 10'd2,    1'b0, 1'b0);
    add_req(ACT_INSERT, 32'h0000_000B, 10'd3,     1'b1, 10'd3,    1'b0, 1'b0);
    add_req(ACT_FIND,   32'h0000_0008, 10'd0,     1'b1, 10'd0,    1'b0, 1'b1);
    add_req(ACT_FIND,   32'h5A5A_5A5A, 10'd0,     1'b0, '0, 1'b0, 1'b0);
    add_req(ACT_INSERT, 32'h0000_0007, 10'd700,   1'b1, 10'd700,  1'b0, 1'b0);
    // Quadratic probing on a non-prime size revisits slots
    add_cfg(REG_PROBE_MODE, CFG_DW'(MODE_QUAD));
    add_cfg(REG_TABLE_SIZE, 32'd6);
    add_req(ACT_INSERT, 32'h0000_0010, 10'd4,     1'b1, 10'd4,    1'b0, 1'b0);
    add_req(ACT_INSERT, 32'h0000_0011, 10'd5,     1'b1, 10'd5,    1'b0, 1'b0);
    add_req(ACT_FIND,   32'd6000,      10'd0,     1'b0, '0, 1'b0, 1'b0);
    // Oversized value clamps to the full depth
    add_cfg(REG_TABLE_SIZE, 32'd2047);
    add_req(ACT_FIND,   32'hFFFF_FFFF, 10'd0,     1'b0, '0, 1'b0, 1'b0);
    add_req(ACT_FIND,   32'h8000_0400, 10'h2AA,   1'b0, '0, 1'b0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res, pred);
      end
    end

    // Random phases, one probe mode and table size each; the last one runs without idling
    for (int ph = 0; ph < 12; ph++) begin
      span = (phase_size[ph] == 0) ? $urandom_range(1, TABLE_DEPTH) : phase_size[ph];
      drain();
      write_reg(REG_PROBE_MODE, (ph < 4) ? CFG_DW'(ph[0]) : CFG_DW'($urandom_range(0, 1)));
      write_reg(REG_TABLE_SIZE, CFG_DW'(span));
      sender_gaps = (ph < 11) && ($urandom_range(0, 3) != 0);
      sink_stalls = (ph < 11) && ($urandom_range(0, 3) != 0);
      count = 0;
      while (count < 128) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Look up a key, then place it where the probe stopped unless it hit or the table was full
          req = '{act: ACT_FIND, key: fresh_key(span), slot: POS_W'($urandom_range(0, 1023))};
          send_request(req, 1'b0, '0, pred);
          count++;
          if (!pred.hit && !pred.table_full) begin
            req.act  = ACT_INSERT;
            req.slot = pred.position;
            send_request(req, 1'b0, '0, pred);
            placed_keys.push_back(req.key);
            if (placed_keys.size() > 64) void'(placed_keys.pop_front());
            count++;
          end
        end else if (pick < 70 && placed_keys.size() != 0) begin
          req = '{act: ACT_FIND, key: placed_keys[$urandom_range(0, placed_keys.size() - 1)],
                  slot: POS_W'($urandom_range(0, 1023))};
          send_request(req, 1'b0, '0, pred);
          count++;
        end else if (pick < 85) begin
          // Overwrite or stray insert, sometimes beyond the table size
          req.act  = ACT_INSERT;
          req.key  = fresh_key(span);
          req.slot = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, span - 1))
                                                 : POS_W'($urandom_range(0, 1023));
          send_request(req, 1'b0, '0, pred);
          count++;
        end else begin
          req = '{act: ACT_FIND, key: $urandom, slot: POS_W'($urandom_range(0, 1023))};
          send_request(req, 1'b0, '0, pred);
          count++;
        end
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d finds and %0d inserts over %0d table sizes in both probe modes.",
             n_find, n_insert, n_settings);
    $display("Compared %0d results: %0d hits, %0d table-full, %0d mismatches.",
             n_checked, n_hit, n_full, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("open_addressing_hash_probe_top verification clean");
    end else begin
      $display("open_addressing_hash_probe_top verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #60_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
    $display("open_addressing_hash_probe_top verification failed");
    $finish;
  end

endmodule
